### sv/smx_pkg.sv
// smx_pkg: shared types and constants for the softmax vector unit.
// Holds the exponential tables and the front-to-back command type.
package smx_pkg;

  localparam int LOGIT_W = 16;
  localparam int PROB_W  = 16;
  localparam int SUM_W   = 22;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic [LOGIT_W-1:0] logit;
    logic               store;
    logic               last;
  } smx_cmd_t;

  function automatic logic [16:0] exp_int(input logic [3:0] n);
    logic [16:0] v;
    case (n)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd24109;
      4'd2:  v = 17'd8869;
      4'd3:  v = 17'd3263;
      4'd4:  v = 17'd1200;
      4'd5:  v = 17'd442;
      4'd6:  v = 17'd162;
      4'd7:  v = 17'd60;
      4'd8:  v = 17'd22;
      4'd9:  v = 17'd8;
      4'd10: v = 17'd3;
      4'd11: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] exp_hi(input logic [3:0] h);
    logic [16:0] v;
    case (h)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd61565;
      4'd2:  v = 17'd57835;
      4'd3:  v = 17'd54331;
      4'd4:  v = 17'd51039;
      4'd5:  v = 17'd47947;
      4'd6:  v = 17'd45042;
      4'd7:  v = 17'd42313;
      4'd8:  v = 17'd39750;
      4'd9:  v = 17'd37341;
      4'd10: v = 17'd35079;
      4'd11: v = 17'd32954;
      4'd12: v = 17'd30957;
      4'd13: v = 17'd29081;
      4'd14: v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] exp_lo(input logic [3:0] l);
    logic [16:0] v;
    case (l)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd65280;
      4'd2:  v = 17'd65026;
      4'd3:  v = 17'd64772;
      4'd4:  v = 17'd64520;
      4'd5:  v = 17'd64268;
      4'd6:  v = 17'd64018;
      4'd7:  v = 17'd63768;
      4'd8:  v = 17'd63520;
      4'd9:  v = 17'd63272;
      4'd10: v = 17'd63025;
      4'd11: v = 17'd62781;
      4'd12: v = 17'd62535;
      4'd13: v = 17'd62291;
      4'd14: v = 17'd62048;
      default: v = 17'd61806;
    endcase
    return v;
  endfunction

endpackage

### sv/softmax_vector_unit.sv
// softmax_vector_unit: top level of the softmax engine.
// Depends on smx_pkg, smx_front and smx_back.
//
// Usage: push signed Q8.8 logits on in_logit with in_is_last on the final
// element; in_full holds pushes off. Up to MAX_LEN elements are kept,
// extra ones are dropped but a final one still closes the vector.
// Results leave as a queue: while out_empty is low, out_probability
// (unsigned Q0.16) and out_last_out show the oldest beat; pop takes it.
// Loading runs at one beat per cycle through a two-entry queue while the
// back end is loading. After the last element the back end runs the
// exponential pass per element (memory read, two multiply stages) and then
// the division pass per element on a bit-serial divider over
// 33 quotient bits. New logits queue up (two deep) meanwhile.
// A stalled receiver holds the division pass; nothing is lost.
// Reset clears all control state; the stores need no clearing.
module softmax_vector_unit #(
  parameter int MAX_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_logit,
  input  logic        in_is_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_probability,
  output logic        out_last_out
);
  logic              cmd_valid, cmd_ready;
  smx_pkg::smx_cmd_t cmd;

  smx_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_logit, .in_is_last,
    .cmd_valid, .cmd, .cmd_ready
  );

  smx_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_ready,
    .out_empty, .out_pop, .out_probability, .out_last_out
  );
endmodule

### sv/smx_front.sv
// smx_front: accepts logit beats, tags those within capacity for storing.
// Depends on smx_pkg.
module smx_front #(
  parameter int MAX_LEN = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [smx_pkg::LOGIT_W-1:0] in_logit,
  input  logic                        in_is_last,
  output logic                        cmd_valid,
  output smx_pkg::smx_cmd_t           cmd,
  input  logic                        cmd_ready
);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    q_cnt_r;
  smx_pkg::smx_cmd_t q_r [2];
  logic          q_head_r, q_tail_r;
  logic          acc, deq;
  smx_pkg::smx_cmd_t c_in;

  assign in_full = (q_cnt_r == 2'd2);
  assign acc     = in_push && !in_full;
  assign deq     = cmd_valid && cmd_ready;
  assign cmd_valid = (q_cnt_r != 2'd0);
  assign cmd     = q_r[q_head_r];

  always_comb begin
    c_in.logit = in_logit;
    c_in.store = (count_r < CW'(MAX_LEN));
    c_in.last  = in_is_last;
    count_nxt  = count_r;
    if (acc) begin
      if (in_is_last) count_nxt = '0;
      else if (c_in.store) count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      q_cnt_r  <= '0;
      q_head_r <= 1'b0;
      q_tail_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (acc) q_tail_r <= ~q_tail_r;
      if (deq) q_head_r <= ~q_head_r;
      q_cnt_r <= q_cnt_r + {1'b0, acc} - {1'b0, deq};
    end
    if (acc) q_r[q_tail_r] <= c_in;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_LEN)) else $error("count over capacity");
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 2'd2) else $error("queue overflow");
  a_last_clr: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_is_last |=> count_r == '0) else $error("count not cleared");
endmodule

### sv/smx_back.sv
// smx_back: stores logits, runs the exponential and division passes, emits.
// Depends on smx_pkg.
module smx_back #(
  parameter int MAX_LEN = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  input  smx_pkg::smx_cmd_t          cmd,
  output logic                       cmd_ready,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [smx_pkg::PROB_W-1:0] out_probability,
  output logic                       out_last_out
);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SW = smx_pkg::SUM_W;

  typedef enum logic [6:0] {
    S_LOAD = 7'b0000001,
    S_ERD  = 7'b0000010,
    S_EM1  = 7'b0000100,
    S_EM2  = 7'b0001000,
    S_DRD  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r;
  logic [smx_pkg::LOGIT_W-1:0] lmem [MAX_LEN];
  logic [15:0] emem [MAX_LEN];
  logic [CW-1:0] count_r, idx_r;
  logic signed [15:0] max_r;
  logic [SW-1:0] sum_r;
  logic [15:0] lrd_r, erd_r;
  logic [3:0]  l_r;
  logic        zero_r;
  logic [33:0] e1_r;
  logic [32:0] num_r;
  logic [SW-1:0] rem_r;
  logic [32:0] quo_r;
  logic [5:0]  bit_r;
  logic [15:0] prob_r;
  logic        plast_r;
  logic        ovalid_r;

  logic [15:0] d;
  logic [33:0] e2_full;
  logic [16:0] e_sat;
  logic [SW:0] sum_add;
  logic [SW:0] rem_sh;
  logic        take;

  assign cmd_ready = (state_r == S_LOAD);
  assign take      = cmd_valid && cmd_ready;
  assign out_empty = !ovalid_r;
  assign out_probability = prob_r;
  assign out_last_out    = plast_r;

  assign d = 16'(max_r - $signed(lrd_r));
  assign e2_full = (34'(e1_r[33:16]) * 34'(smx_pkg::exp_lo(l_r))) + 34'd32768;
  assign e_sat = (e2_full[33:16] > 18'd65535) ? 17'd65535 : e2_full[32:16];
  assign sum_add = {1'b0, sum_r} + (SW+1)'(e_sat[15:0]);
  assign rem_sh = {rem_r, num_r[32]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      count_r  <= '0;
      idx_r    <= '0;
      max_r    <= 16'sh8000;
      sum_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && out_pop) ovalid_r <= 1'b0;
      case (state_r)
        S_LOAD: begin
          if (take) begin
            if (cmd.store) begin
              count_r <= count_r + CW'(1);
              if ($signed(cmd.logit) > max_r) max_r <= $signed(cmd.logit);
            end
            if (cmd.last) begin
              idx_r   <= '0;
              sum_r   <= '0;
              state_r <= S_ERD;
            end
          end
        end
        S_ERD: begin
          state_r <= S_EM1;
        end
        S_EM1: begin
          state_r <= S_EM2;
        end
        S_EM2: begin
          if (!zero_r) begin
            sum_r <= sum_add[SW] ? smx_pkg::SUM_MAX : sum_add[SW-1:0];
          end
          if (idx_r + CW'(1) >= count_r) begin
            idx_r   <= '0;
            state_r <= S_DRD;
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_ERD;
          end
        end
        S_DRD: begin
          bit_r   <= 6'd33;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (bit_r == 6'd0) begin
            state_r <= S_OUT;
          end else begin
            bit_r <= bit_r - 6'd1;
          end
        end
        S_OUT: begin
          if (!ovalid_r || out_pop) begin
            ovalid_r <= 1'b1;
            if (idx_r + CW'(1) >= count_r) begin
              count_r <= '0;
              max_r   <= 16'sh8000;
              sum_r   <= '0;
              state_r <= S_LOAD;
            end else begin
              idx_r   <= idx_r + CW'(1);
              state_r <= S_DRD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && take && cmd.store) lmem[count_r[AW-1:0]] <= cmd.logit;
    if (state_r == S_ERD) lrd_r <= lmem[idx_r[AW-1:0]];
    if (state_r == S_EM1) begin
      zero_r <= (d[15:8] >= 8'd12);
      l_r    <= d[3:0];
      e1_r   <= 34'(smx_pkg::exp_int(d[11:8])) * 34'(smx_pkg::exp_hi(d[7:4])) + 34'd32768;
    end
    if (state_r == S_EM2) begin
      emem[idx_r[AW-1:0]] <= zero_r ? 16'd0 : e_sat[15:0];
    end
    if (state_r == S_DRD) erd_r <= emem[idx_r[AW-1:0]];
    if (state_r == S_DIV) begin
      if (bit_r == 6'd33) begin
        num_r <= {1'b0, erd_r, 16'd0} + 33'(sum_r >> 1);
        rem_r <= '0;
        quo_r <= '0;
      end else begin
        num_r <= {num_r[31:0], 1'b0};
        if (rem_sh >= {1'b0, sum_r}) begin
          rem_r <= SW'(rem_sh - {1'b0, sum_r});
          quo_r <= {quo_r[31:0], 1'b1};
        end else begin
          rem_r <= rem_sh[SW-1:0];
          quo_r <= {quo_r[31:0], 1'b0};
        end
      end
    end
    if (state_r == S_OUT && (!ovalid_r || out_pop)) begin
      prob_r  <= (sum_r == '0) ? 16'd0 :
                 (quo_r[32:16] != 17'd0) ? 16'hFFFF : quo_r[15:0];
      plast_r <= (idx_r + CW'(1) >= count_r);
    end
  end

  a_ready_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_ready |-> state_r == S_LOAD) else $error("ready outside load");
  a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r) == S_OUT) else $error("stray beat");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_LEN)) else $error("count over capacity");
endmodule

### tb/tb_softmax_vector_unit.sv
// tb_softmax_vector_unit: self-checking testbench for the softmax vector unit.
// Drives logit vectors in bursts through a directed table and then random vectors.
// Checks each beat against a softmax predictor or typed table values; needs smx_pkg.
module tb_softmax_vector_unit;

  localparam int MAX_LEN   = 64;
  localparam int CYC_LIMIT = 2000000;

  typedef struct {
    logic [15:0] prob;
    logic        last;
  } prob_beat_t;

  typedef struct {
    logic [15:0] logit;
    logic        last;
    logic        known;
    logic [15:0] prob;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [15:0] in_logit = '0;
  logic        in_is_last = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [15:0] out_probability;
  logic        out_last_out;

  softmax_vector_unit #(.MAX_LEN(MAX_LEN)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_logit(in_logit), .in_is_last(in_is_last),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_probability(out_probability), .out_last_out(out_last_out)
  );

  always #1 clk = ~clk;

  localparam logic [16:0] EXP_WHOLE [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                            22, 8, 3, 1};
  localparam logic [16:0] EXP_HIGH [16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
                                           42313, 39750, 37341, 35079, 32954, 30957, 29081,
                                           27319, 25664};
  localparam logic [16:0] EXP_LOW [16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018,
                                          63768, 63520, 63272, 63025, 62781, 62535, 62291,
                                          62048, 61806};

  prob_beat_t  prob_q[$];
  logic signed [15:0] vec_logits[$];
  logic        vec_known[$];
  logic [15:0] vec_typed[$];
  logic signed [15:0] vec_max = -16'sd32768;
  int          errors = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          hold_req = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic logic [15:0] exp_of_gap(input logic [15:0] gap);
    logic [63:0] e;
    if (gap[15:8] >= 8'd12) return 16'd0;
    e = EXP_WHOLE[gap[11:8]];
    e = (e * EXP_HIGH[gap[7:4]] + 64'd32768) >> 16;
    e = (e * EXP_LOW[gap[3:0]] + 64'd32768) >> 16;
    return (e > 64'd65535) ? 16'd65535 : e[15:0];
  endfunction

  task automatic predict_logit(input logic [15:0] logit, input logic last,
                               input logic known, input logic [15:0] typed);
    logic [15:0] exps[$];
    logic [21:0] total;
    logic [63:0] p;
    int          n;
    if (vec_logits.size() < MAX_LEN) begin
      vec_logits.push_back(logit);
      vec_known.push_back(known);
      vec_typed.push_back(typed);
      if ($signed(logit) > vec_max) vec_max = logit;
    end
    if (!last) return;
    n = vec_logits.size();
    total = '0;
    for (int i = 0; i < n; i++) begin
      exps.push_back(exp_of_gap(16'(vec_max - vec_logits[i])));
      total = (23'(total) + 23'(exps[i]) > 23'(smx_pkg::SUM_MAX)) ? smx_pkg::SUM_MAX :
              22'(total + 22'(exps[i]));
    end
    for (int i = 0; i < n; i++) begin
      p = 0;
      if (total != 0) begin
        p = ((64'(exps[i]) << 16) + (total >> 1)) / total;
        if (p > 64'd65535) p = 64'd65535;
      end
      if (vec_known[i]) p = vec_typed[i];
      prob_q.push_back('{prob: p[15:0], last: (i == n - 1)});
    end
    vec_logits.delete();
    vec_known.delete();
    vec_typed.delete();
    vec_max = -16'sd32768;
  endtask

  task automatic push_beat(input logic [15:0] logit, input logic last,
                           input logic known, input logic [15:0] typed);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_push    <= 1'b1;
    in_logit   <= logit;
    in_is_last <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_logit(logit, last, known, typed);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && !out_empty && out_pop) begin
      if (prob_q.size() == 0) begin
        report("unexpected beat", out_probability, 0);
      end else begin
        if (out_probability !== prob_q[0].prob)
          report("probability", out_probability, prob_q[0].prob);
        if (out_last_out !== prob_q[0].last)
          report("last_out", out_last_out, prob_q[0].last);
        void'(prob_q.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req > 0) begin
      out_pop <= 1'b0;
      hold_req--;
    end else if ((cycles / 64) % 3 == 0) begin
      out_pop <= 1'b1;
    end else begin
      out_pop <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("softmax_vector_unit test failed");
      $finish;
    end
  end

  stim_row_t table_rows[] = '{
    '{16'h0100, 1'b1, 1'b1, 16'd65535},
    '{16'h0000, 1'b0, 1'b1, 16'd32768},
    '{16'h0000, 1'b1, 1'b1, 16'd32768},
    '{16'h7FFF, 1'b0, 1'b1, 16'd65535},
    '{16'h8000, 1'b1, 1'b1, 16'd0},
    '{16'h8000, 1'b0, 1'b1, 16'd32768},
    '{16'h8000, 1'b1, 1'b1, 16'd32768},
    '{16'h0000, 1'b0, 1'b0, 16'd0},
    '{16'hFF11, 1'b0, 1'b0, 16'd0},
    '{16'hFA00, 1'b0, 1'b0, 16'd0},
    '{16'hF4FF, 1'b1, 1'b0, 16'd0},
    '{16'h0C00, 1'b0, 1'b0, 16'd0},
    '{16'h0001, 1'b0, 1'b0, 16'd0},
    '{16'h0000, 1'b1, 1'b0, 16'd0},
    '{16'h5555, 1'b0, 1'b0, 16'd0},
    '{16'hAAAA, 1'b0, 1'b0, 16'd0},
    '{16'h54F0, 1'b1, 1'b0, 16'd0}
  };

  initial begin
    int          items;
    int          len;
    int          base;
    logic [15:0] lg;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (table_rows[i])
      push_beat(table_rows[i].logit, table_rows[i].last, table_rows[i].known, table_rows[i].prob);
    hold_req = 400;
    items = table_rows.size();
    for (int v = 0; items < 150; v++) begin
      len = (v == 3) ? 70 : (v == 9) ? MAX_LEN : $urandom_range(1, 8);
      base = $urandom_range(0, 65535);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 3) == 0) lg = 16'($urandom_range(0, 65535));
        else lg = 16'(base + $urandom_range(0, 2047) - 1024);
        push_beat(lg, (k == len - 1), 1'b0, 16'd0);
        items++;
      end
    end
    in_push <= 1'b0;
    while (prob_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && prob_q.size() == 0) begin
      $display("softmax_vector_unit test passed");
    end else begin
      $display("softmax_vector_unit test failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/smx_pkg.sv
sv/smx_front.sv
sv/smx_back.sv
sv/softmax_vector_unit.sv
tb/tb_softmax_vector_unit.sv
